// ===== hdl/brlt_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// brlt_pkg
// shared types and codes of the bracket checked run length tokenizer
// ---------------------------------------------------------------------------
package brlt_pkg;

  localparam logic [3:0] OP_PLUS   = 4'd0;
  localparam logic [3:0] OP_MINUS  = 4'd1;
  localparam logic [3:0] OP_RIGHT  = 4'd2;
  localparam logic [3:0] OP_LEFT   = 4'd3;
  localparam logic [3:0] OP_OUTPUT = 4'd4;
  localparam logic [3:0] OP_INPUT  = 4'd5;
  localparam logic [3:0] OP_OPEN   = 4'd6;
  localparam logic [3:0] OP_CLOSE  = 4'd7;
  localparam logic [3:0] OP_END    = 4'd8;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNM_CLOSE = 2'd1;
  localparam logic [1:0] ERR_UNM_OPEN  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_RIGHT  = 8'h3e;
  localparam logic [7:0] CH_LEFT   = 8'h3c;
  localparam logic [7:0] CH_OUTPUT = 8'h2e;
  localparam logic [7:0] CH_INPUT  = 8'h2c;
  localparam logic [7:0] CH_OPEN   = 8'h5b;
  localparam logic [7:0] CH_CLOSE  = 8'h5d;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] repeat_res;
    logic [7:0]  depth;
    logic [1:0]  error;
    logic [31:0] position;
    logic        last;
  } brlt_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    brlt_res_t  r0;
    brlt_res_t  r1;
  } brlt_step_t;

endpackage
`default_nettype wire

// ===== hdl/brlt_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// brlt_core
// tokenizer state and the single pass step that yields up to two results
// ---------------------------------------------------------------------------
module brlt_core
  import brlt_pkg::*;
#(
  parameter int RUN_MAX   = 65535,
  parameter int DEPTH_MAX = 255
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic       kind,
  input  wire logic [7:0] ch,
  output brlt_step_t      step
);

  logic [2:0]  run_op_r, run_op_nxt;
  logic        run_valid_r, run_valid_nxt;
  logic [15:0] run_count_r, run_count_nxt;
  logic [7:0]  nest_depth_r, nest_depth_nxt;
  logic [31:0] char_index_r, char_index_nxt;
  logic        halted_r, halted_nxt;

  logic        is_simple, is_open, is_close;
  logic [2:0]  sop;
  logic        extend, flush, has_main;
  brlt_res_t   flush_res, main_res;

  always_comb begin
    is_simple = 1'b1;
    is_open   = 1'b0;
    is_close  = 1'b0;
    sop       = 3'd0;
    case (ch)
      CH_PLUS:   sop = OP_PLUS[2:0];
      CH_MINUS:  sop = OP_MINUS[2:0];
      CH_RIGHT:  sop = OP_RIGHT[2:0];
      CH_LEFT:   sop = OP_LEFT[2:0];
      CH_OUTPUT: sop = OP_OUTPUT[2:0];
      CH_INPUT:  sop = OP_INPUT[2:0];
      CH_OPEN: begin
        is_simple = 1'b0;
        is_open   = 1'b1;
      end
      CH_CLOSE: begin
        is_simple = 1'b0;
        is_close  = 1'b1;
      end
      default:   is_simple = 1'b0;
    endcase
  end

  always_comb begin
    extend = run_valid_r && (run_op_r == sop) && (run_count_r < 16'(RUN_MAX));
    if (kind == KIND_END) begin
      flush    = run_valid_r;
      has_main = 1'b1;
    end else begin
      flush    = run_valid_r && ((is_simple && !extend) || is_open || is_close);
      has_main = is_open || is_close;
    end

    flush_res.op         = {1'b0, run_op_r};
    flush_res.repeat_res = run_count_r;
    flush_res.depth      = nest_depth_r;
    flush_res.error      = ERR_NONE;
    flush_res.position   = '0;
    flush_res.last       = !has_main;

    main_res.repeat_res = '0;
    main_res.depth      = nest_depth_r;
    main_res.position   = '0;
    main_res.last       = 1'b1;
    main_res.error      = ERR_NONE;
    if (kind == KIND_END) begin
      main_res.op = OP_END;
      if (nest_depth_r != 8'd0) main_res.error = ERR_UNM_OPEN;
    end else if (is_open) begin
      main_res.op = OP_OPEN;
      if (nest_depth_r >= 8'(DEPTH_MAX)) begin
        main_res.error    = ERR_OVERFLOW;
        main_res.position = char_index_r;
      end
    end else begin
      main_res.op = OP_CLOSE;
      if (nest_depth_r == 8'd0) begin
        main_res.error    = ERR_UNM_CLOSE;
        main_res.position = char_index_r;
      end
    end

    step.r0 = flush ? flush_res : main_res;
    step.r1 = main_res;
    if (!step_en || halted_r) step.cnt = 2'd0;
    else                      step.cnt = {1'b0, flush} + {1'b0, has_main};
  end

  always_comb begin
    run_op_nxt     = run_op_r;
    run_valid_nxt  = run_valid_r;
    run_count_nxt  = run_count_r;
    nest_depth_nxt = nest_depth_r;
    char_index_nxt = char_index_r;
    halted_nxt     = halted_r;
    if (step_en && !halted_r) begin
      if (flush) begin
        run_valid_nxt = 1'b0;
        run_count_nxt = '0;
      end
      if (kind == KIND_END) begin
        halted_nxt = 1'b1;
      end else begin
        char_index_nxt = char_index_r + 32'd1;
        if (is_simple) begin
          if (extend) begin
            run_count_nxt = run_count_r + 16'd1;
          end else begin
            run_op_nxt    = sop;
            run_count_nxt = 16'd1;
            run_valid_nxt = 1'b1;
          end
        end else if (is_open) begin
          if (nest_depth_r >= 8'(DEPTH_MAX)) halted_nxt = 1'b1;
          else nest_depth_nxt = nest_depth_r + 8'd1;
        end else if (is_close) begin
          if (nest_depth_r == 8'd0) halted_nxt = 1'b1;
          else nest_depth_nxt = nest_depth_r - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_op_r     <= '0;
      run_valid_r  <= 1'b0;
      run_count_r  <= '0;
      nest_depth_r <= '0;
      char_index_r <= '0;
      halted_r     <= 1'b0;
    end else begin
      run_op_r     <= run_op_nxt;
      run_valid_r  <= run_valid_nxt;
      run_count_r  <= run_count_nxt;
      nest_depth_r <= nest_depth_nxt;
      char_index_r <= char_index_nxt;
      halted_r     <= halted_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/brlt_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// brlt_fifo
// result queue taking up to two results per cycle and giving one while out_ready is high
// ---------------------------------------------------------------------------
module brlt_fifo
  import brlt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  brlt_step_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output brlt_res_t  out_res
);

  brlt_res_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 pop;

  assign room      = count_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW + 1)'(push.cnt) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bracket_checked_run_length_tokenizer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bracket_checked_run_length_tokenizer
// merges runs of command symbols into tokens and checks bracket nesting
// ---------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata: ch; tuser: kind (1 = end of source)
//  out_    | master    | tdata: op, repeat_res, depth, error, position; tlast: last
//
//  one input transfer per cycle while the input is not stalled; its path runs
//  through the input register, one step of logic and the result queue, and a
//  result can be taken once it is in the queue; the input stalls while the
//  four entry result queue holds more than two results
//  synchronous active low reset clears the run, depth, position and halt state
//  after an end item or an error, further items are taken and dropped until reset
// ---------------------------------------------------------------------------
module bracket_checked_run_length_tokenizer
  import brlt_pkg::*;
#(
  parameter int RUN_MAX   = 65535,
  parameter int DEPTH_MAX = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // ch[7:0]
  input  wire logic        in_tuser,   // kind[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // op[3:0] repeat_res[19:4] depth[27:20]
                                       // error[29:28] position[61:30] zero[63:62]
  output logic             out_tlast
);

  logic       in_vld_r, in_vld_nxt;
  logic       in_kind_r;
  logic [7:0] in_ch_r;
  logic       room, step_en;
  brlt_step_t step;
  brlt_res_t  res;

  assign step_en    = in_vld_r && room;
  assign in_tready  = !in_vld_r || step_en;
  assign in_vld_nxt = in_tready ? in_tvalid : in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= in_tuser;
      in_ch_r   <= in_tdata;
    end
  end

  brlt_core #(
    .RUN_MAX   (RUN_MAX),
    .DEPTH_MAX (DEPTH_MAX)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .kind    (in_kind_r),
    .ch      (in_ch_r),
    .step    (step)
  );

  brlt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.position, res.error, res.depth, res.repeat_res, res.op};
  assign out_tlast = res.last;

endmodule
`default_nettype wire

// ===== sim/brlt_token_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// brlt_token_checker
// watches the character and token channels of the tokenizer, works out the
// tokens each accepted character must give and compares every token transfer
// field by field with the oldest prediction still waiting
// ---------------------------------------------------------------------------
module brlt_token_checker
  import brlt_pkg::*;
#(
  parameter int RUN_MAX   = 65535,
  parameter int DEPTH_MAX = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // ch[7:0]
  input  wire logic        in_tuser,   // kind[0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [63:0] out_tdata,  // op[3:0] repeat_res[19:4] depth[27:20]
                                       // error[29:28] position[61:30] zero[63:62]
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending
);

  brlt_res_t   token_q[$];
  brlt_res_t   step_tok[2];
  int          step_cnt;

  logic [3:0]  run_kind;
  logic        run_live;
  logic [15:0] run_len;
  logic [7:0]  nest;
  logic [31:0] char_pos;
  logic        stopped;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic post(input logic [3:0] op, input logic [15:0] rep, input logic [7:0] dep,
                      input logic [1:0] err, input logic [31:0] pos);
    brlt_res_t tok;
    tok            = '0;
    tok.op         = op;
    tok.repeat_res = rep;
    tok.depth      = dep;
    tok.error      = err;
    tok.position   = pos;
    step_tok[step_cnt] = tok;
    step_cnt++;
  endtask

  task automatic flush_run();
    if (run_live) begin
      post(run_kind, run_len, nest, ERR_NONE, 32'd0);
      run_live = 1'b0;
      run_len  = '0;
    end
  endtask

  task automatic tokenize(input logic kind, input logic [7:0] ch);
    logic [3:0]  cmd;
    logic        is_cmd;
    logic [31:0] pos;
    brlt_res_t   tok;
    int          i;
    step_cnt = 0;
    if (!stopped) begin
      if (kind == KIND_END) begin
        flush_run();
        if (nest != 8'd0) post(OP_END, 16'd0, nest, ERR_UNM_OPEN, 32'd0);
        else post(OP_END, 16'd0, 8'd0, ERR_NONE, 32'd0);
        stopped = 1'b1;
      end else begin
        pos      = char_pos;
        char_pos = char_pos + 32'd1;
        is_cmd   = 1'b1;
        cmd      = OP_PLUS;
        case (ch)
          CH_PLUS:   cmd = OP_PLUS;
          CH_MINUS:  cmd = OP_MINUS;
          CH_RIGHT:  cmd = OP_RIGHT;
          CH_LEFT:   cmd = OP_LEFT;
          CH_OUTPUT: cmd = OP_OUTPUT;
          CH_INPUT:  cmd = OP_INPUT;
          CH_OPEN:   cmd = OP_OPEN;
          CH_CLOSE:  cmd = OP_CLOSE;
          default:   is_cmd = 1'b0;
        endcase
        if (!is_cmd) begin
          // other bytes only move the position
        end else if (cmd == OP_OPEN) begin
          flush_run();
          if (nest >= DEPTH_MAX) begin
            post(OP_OPEN, 16'd0, nest, ERR_OVERFLOW, pos);
            stopped = 1'b1;
          end else begin
            post(OP_OPEN, 16'd0, nest, ERR_NONE, 32'd0);
            nest = nest + 8'd1;
          end
        end else if (cmd == OP_CLOSE) begin
          flush_run();
          if (nest == 8'd0) begin
            post(OP_CLOSE, 16'd0, 8'd0, ERR_UNM_CLOSE, pos);
            stopped = 1'b1;
          end else begin
            post(OP_CLOSE, 16'd0, nest, ERR_NONE, 32'd0);
            nest = nest - 8'd1;
          end
        end else if (run_live && run_kind == cmd && run_len < RUN_MAX) begin
          run_len = run_len + 16'd1;
        end else begin
          // a full run is split here as well
          flush_run();
          run_kind = cmd;
          run_len  = 16'd1;
          run_live = 1'b1;
        end
      end
    end
    for (i = 0; i < step_cnt; i++) begin
      tok      = step_tok[i];
      tok.last = (i == step_cnt - 1);
      token_q.push_back(tok);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    brlt_res_t want;
    if (!rst_n) begin
      run_kind = OP_PLUS;
      run_live = 1'b0;
      run_len  = '0;
      nest     = '0;
      char_pos = '0;
      stopped  = 1'b0;
      token_q.delete();
    end else begin
      if (in_tvalid && in_tready) tokenize(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          $display("%0t: token expected none got tdata %0h last %0b",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = token_q.pop_front();
          check_field("op", want.op, out_tdata[3:0]);
          check_field("repeat", want.repeat_res, out_tdata[19:4]);
          check_field("depth", want.depth, out_tdata[27:20]);
          check_field("error", want.error, out_tdata[29:28]);
          check_field("position", want.position, out_tdata[61:30]);
          check_field("pad", 32'd0, out_tdata[63:62]);
          check_field("last", want.last, out_tlast);
        end
      end
    end
    pending = token_q.size();
  end

endmodule
`default_nettype wire

// ===== sim/bracket_checked_run_length_tokenizer_test.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bracket_checked_run_length_tokenizer_test
// feeds the tokenizer a short hand written program, a long random program of
// runs, noise bytes and nested brackets, a climb into deep nesting, and one
// randomly chosen way of ending the source, the overflow ending climbing to
// the deepest level; a checker beside the block predicts and compares every token
// ---------------------------------------------------------------------------
module bracket_checked_run_length_tokenizer_test;
  import brlt_pkg::*;

  localparam int  RANDOM_ITEMS    = 560;
  localparam int  HOLD_OFF_CYCLES = 300;
  localparam int  END_PAUSE       = 16;
  localparam int  MID_DEPTH       = 128;
  localparam int  TOP_DEPTH       = 255;
  localparam int  RAND_DEPTH_CAP  = 200;
  localparam time RUN_LIMIT       = 20_000_000;

  localparam int ENDS_CLEAN       = 0;
  localparam int ENDS_OPEN        = 1;
  localparam int ENDS_STRAY_CLOSE = 2;
  localparam int ENDS_OVERFLOW    = 3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // ch[7:0]
  logic        in_tuser;   // kind[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // op[3:0] repeat_res[19:4] depth[27:20]
                           // error[29:28] position[61:30] zero[63:62]
  logic        out_tlast;

  int fail_count;
  int pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  bit hold_off_req;
  int src_depth;

  bracket_checked_run_length_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  brlt_token_checker token_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] simple_char(input int idx);
    case (idx)
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_RIGHT;
      3:       return CH_LEFT;
      4:       return CH_OUTPUT;
      default: return CH_INPUT;
    endcase
  endfunction

  // valid stays high from one transfer to the next unless a gap is drawn
  task automatic push(input logic kind, input logic [7:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_CHAR && ch == CH_OPEN) src_depth++;
    else if (kind == KIND_CHAR && ch == CH_CLOSE && src_depth > 0) src_depth--;
  endtask

  task automatic push_char(input logic [7:0] ch);
    push(KIND_CHAR, ch);
  endtask

  // mostly runs and brackets with no unmatched close, some noise bytes in between
  task automatic random_source(input int count);
    int         sent;
    int         len;
    int         pick;
    logic [7:0] c;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        do c = 8'($urandom_range(255)); while (c == CH_OPEN || c == CH_CLOSE);
        push_char(c);
        sent++;
      end else if (pick < 65) begin
        c   = simple_char($urandom_range(5));
        len = $urandom_range(6, 1);
        repeat (len) begin
          push_char(c);
          sent++;
        end
      end else if ((pick < 82 && src_depth < RAND_DEPTH_CAP) || src_depth == 0) begin
        push_char(CH_OPEN);
        sent++;
      end else begin
        push_char(CH_CLOSE);
        sent++;
      end
    end
  endtask

  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // long hold so the token queue fills and the input stalls
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    string directed;
    int    mode;
    int    climb;
    int    i;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'd0;
    in_tuser     = KIND_CHAR;
    snd_idle_pct = 26;
    rcv_idle_pct = 74;
    hold_off_req = 1'b0;
    src_depth    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // noise inside a run, every op, run breaks, brackets after a pending run
    push_char(CH_PLUS);
    push_char(8'h00);
    push_char(CH_PLUS);
    push_char(8'hff);
    push_char(CH_PLUS);
    directed = "-->><.,,[+][[]]..";
    for (i = 0; i < directed.len(); i++) push_char(directed[i]);

    random_source(RANDOM_ITEMS / 3);
    snd_idle_pct = 74;
    rcv_idle_pct = 26;
    random_source(RANDOM_ITEMS / 3);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_off_req = 1'b1;
    random_source(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    mode  = $urandom_range(ENDS_OVERFLOW, ENDS_CLEAN);
    climb = (mode == ENDS_OVERFLOW) ? TOP_DEPTH : MID_DEPTH;
    while (src_depth < climb) push_char(CH_OPEN);
    push_char(CH_OUTPUT);

    case (mode)
      ENDS_CLEAN: begin
        while (src_depth > 0) push_char(CH_CLOSE);
        push_char(CH_PLUS);
        push_char(CH_PLUS);
        push(KIND_END, 8'($urandom_range(255)));
      end
      ENDS_OPEN: begin
        while (src_depth > 0) push_char(CH_CLOSE);
        push_char(CH_OPEN);
        push_char(CH_OPEN);
        push_char(CH_MINUS);
        push(KIND_END, 8'($urandom_range(255)));
      end
      ENDS_STRAY_CLOSE: begin
        while (src_depth > 0) push_char(CH_CLOSE);
        push_char(CH_RIGHT);
        push_char(CH_CLOSE);
      end
      default: begin
        push_char(CH_OPEN);
      end
    endcase

    // halted: these are taken and dropped
    repeat (8) push(1'($urandom_range(1)), 8'($urandom_range(255)));
    @(negedge clk);
    in_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (END_PAUSE) @(posedge clk);
    if (pending != 0) $display("%0t: %0d tokens never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/brlt_pkg.sv
hdl/brlt_core.sv
hdl/brlt_fifo.sv
hdl/bracket_checked_run_length_tokenizer.sv
sim/brlt_token_checker.sv
sim/bracket_checked_run_length_tokenizer_test.sv
